// ----- src/laser_scan_wander_avoider_macros.svh -----
// ----------------------------------------------------------------------------
// laser scan wander avoider assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef LASER_SCAN_WANDER_AVOIDER_MACROS_SVH
`define LASER_SCAN_WANDER_AVOIDER_MACROS_SVH

// checked only outside reset
`define LSWA_CHECK(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

// checked during reset too
`define LSWA_CHECK_ALWAYS(name, ck, prop, msg) \
  name: assert property (@(posedge ck) prop) \
    else $error(msg);

`endif

// ----- src/lswa_pkg.sv -----
// ----------------------------------------------------------------------------
// lswa_pkg
// widths, register codes, reset values and shared types of the wander avoider
// ----------------------------------------------------------------------------
package lswa_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int RANGE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int SCAN_BITS     = 12;
  localparam int THR_BITS      = 16;
  localparam int DUR_BITS      = 8;
  localparam int SPEED_BITS    = 16;
  localparam int RATE_BITS     = 15;
  localparam int TURN_BITS     = 16;
  localparam int CNT_BITS      = 9;
  localparam int LFSR_BITS     = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCAN_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRONT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AVOID_DURATION  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CRUISE_SPEED    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AVOID_SPEED     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AVOID_TURN_RATE = 3'd6;

  localparam int SCAN_LENGTH_RST = 361;
  localparam logic [SCAN_BITS-1:0] LAST_IDX_RST = SCAN_BITS'(SCAN_LENGTH_RST - 1);
  localparam logic [SCAN_BITS-1:0] THIRD_RST    = SCAN_BITS'(SCAN_LENGTH_RST / 3);
  localparam logic [SCAN_BITS-1:0] UPPER_RST    =
    SCAN_BITS'(SCAN_LENGTH_RST - SCAN_LENGTH_RST / 3);
  localparam logic [SCAN_BITS-1:0] HALF_RST     = SCAN_BITS'(SCAN_LENGTH_RST / 2);

  localparam logic [THR_BITS-1:0]   FRONT_THR_RST   = 16'd2000;
  localparam logic [THR_BITS-1:0]   STOP_THR_RST    = 16'd100;
  localparam logic [DUR_BITS-1:0]   AVOID_DUR_RST   = 8'd5;
  localparam logic [SPEED_BITS-1:0] CRUISE_SPD_RST  = 16'd100;
  localparam logic [SPEED_BITS-1:0] AVOID_SPD_RST   = 16'd20;
  localparam logic [RATE_BITS-1:0]  TURN_RATE_RST   = 15'd500;
  localparam logic [CNT_BITS-1:0]   AVOID_CNT_RST   = 9'd4;
  localparam logic [LFSR_BITS-1:0]  LFSR_RST        = 16'hACE1;

  // floor(n/3) by reciprocal multiply, then one correction step
  localparam int DIV3_SHIFT = SCAN_BITS + 2;
  localparam int DIV3_MUL_BITS = SCAN_BITS + 1;
  localparam logic [DIV3_MUL_BITS-1:0] DIV3_MUL = DIV3_MUL_BITS'((1 << DIV3_SHIFT) / 3);

  typedef struct packed {
    logic [SCAN_BITS-1:0] last_idx;
    logic [SCAN_BITS-1:0] third;
    logic [SCAN_BITS-1:0] upper;
    logic [SCAN_BITS-1:0] half;
    logic [THR_BITS-1:0]  front_thr;
    logic [THR_BITS-1:0]  stop_thr;
  } scan_cfg_t;

  typedef struct packed {
    logic [DUR_BITS-1:0]   dur;
    logic [SPEED_BITS-1:0] cruise_speed;
    logic [SPEED_BITS-1:0] avoid_speed;
    logic [RATE_BITS-1:0]  turn_rate;
  } drive_cfg_t;

  function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_BITS-1:1]};
  endfunction

endpackage

// ----- src/laser_scan_wander_avoider.sv -----
// ----------------------------------------------------------------------------
// laser_scan_wander_avoider
// wander controller: per-scan obstacle summary and random-length avoidance turns
// throughput: one range item per clock unless a full queue holds a scan's last item;
// the command of a scan is registered through the summary queue and the output, and
// a new episode first runs the 16-step modulo, so scans shorter than it can stall input
// reset: registers to defaults, scan cleared, avoid count 4, lfsr 0xace1
// ----------------------------------------------------------------------------
module laser_scan_wander_avoider #(
  parameter int INDEX_BITS = lswa_pkg::INDEX_BITS_DEF,
  parameter int RANGE_BITS = lswa_pkg::RANGE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wen,
  input  logic [lswa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lswa_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [RANGE_BITS-1:0]                   range_mm,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [lswa_pkg::SPEED_BITS-1:0]         linear_speed,
  output logic signed [lswa_pkg::TURN_BITS-1:0]   turn_rate,
  output logic                                    avoiding,
  output logic                                    stopped,
  output logic [lswa_pkg::CNT_BITS-1:0]           avoid_remaining
);

  localparam int SB = lswa_pkg::SCAN_BITS;
  localparam int QW = 2 * RANGE_BITS + 2;
  localparam int PB = SB + lswa_pkg::DIV3_MUL_BITS;

  lswa_pkg::scan_cfg_t  scfg;
  lswa_pkg::drive_cfg_t dcfg;

  logic [SB-1:0] n_wr;
  logic [PB-1:0] n_prod;
  logic [SB-1:0] q3_est;
  logic [SB-1:0] q3_rem;
  logic [SB-1:0] q3;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_valid;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_head;

  // scan geometry worked out when the length is written
  assign n_wr   = (cfg_data[SB-1:0] == '0) ? SB'(1) : cfg_data[SB-1:0];
  assign n_prod = PB'(n_wr) * PB'(lswa_pkg::DIV3_MUL);
  assign q3_est = SB'(n_prod >> lswa_pkg::DIV3_SHIFT);
  assign q3_rem = n_wr - ((q3_est << 1) + q3_est);
  assign q3     = (q3_rem >= SB'(3)) ? q3_est + SB'(1) : q3_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      scfg.last_idx     <= lswa_pkg::LAST_IDX_RST;
      scfg.third        <= lswa_pkg::THIRD_RST;
      scfg.upper        <= lswa_pkg::UPPER_RST;
      scfg.half         <= lswa_pkg::HALF_RST;
      scfg.front_thr    <= lswa_pkg::FRONT_THR_RST;
      scfg.stop_thr     <= lswa_pkg::STOP_THR_RST;
      dcfg.dur          <= lswa_pkg::AVOID_DUR_RST;
      dcfg.cruise_speed <= lswa_pkg::CRUISE_SPD_RST;
      dcfg.avoid_speed  <= lswa_pkg::AVOID_SPD_RST;
      dcfg.turn_rate    <= lswa_pkg::TURN_RATE_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        lswa_pkg::CFG_SCAN_LENGTH: begin
          scfg.last_idx <= n_wr - SB'(1);
          scfg.third    <= q3;
          scfg.upper    <= n_wr - q3;
          scfg.half     <= n_wr >> 1;
        end
        lswa_pkg::CFG_FRONT_THRESHOLD: begin
          scfg.front_thr <= cfg_data;
        end
        lswa_pkg::CFG_STOP_THRESHOLD: begin
          scfg.stop_thr <= cfg_data;
        end
        lswa_pkg::CFG_AVOID_DURATION: begin
          dcfg.dur <= cfg_data[lswa_pkg::DUR_BITS-1:0];
        end
        lswa_pkg::CFG_CRUISE_SPEED: begin
          dcfg.cruise_speed <= cfg_data;
        end
        lswa_pkg::CFG_AVOID_SPEED: begin
          dcfg.avoid_speed <= cfg_data;
        end
        lswa_pkg::CFG_AVOID_TURN_RATE: begin
          dcfg.turn_rate <= cfg_data[lswa_pkg::RATE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lswa_front #(
    .INDEX_BITS (INDEX_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .scfg     (scfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .range_mm (range_mm),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  lswa_fifo #(
    .WIDTH (QW),
    .DEPTH (lswa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  lswa_back #(
    .RANGE_BITS (RANGE_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .dcfg            (dcfg),
    .q_valid         (q_valid),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .linear_speed    (linear_speed),
    .turn_rate       (turn_rate),
    .avoiding        (avoiding),
    .stopped         (stopped),
    .avoid_remaining (avoid_remaining)
  );

endmodule

// ----- src/lswa_fifo.sv -----
// ----------------------------------------------------------------------------
// lswa_fifo
// short flop queue carrying scan summaries from the front to the back end
// ----------------------------------------------------------------------------
module lswa_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = lswa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- src/lswa_front.sv -----
// ----------------------------------------------------------------------------
// lswa_front
// takes range samples, classifies them by index and folds each scan into a summary
// ----------------------------------------------------------------------------
module lswa_front #(
  parameter int INDEX_BITS = lswa_pkg::INDEX_BITS_DEF,
  parameter int RANGE_BITS = lswa_pkg::RANGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lswa_pkg::scan_cfg_t       scfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RANGE_BITS-1:0]     range_mm,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [2*RANGE_BITS+1:0]   q_data
);

  localparam int CW = (INDEX_BITS > lswa_pkg::SCAN_BITS) ? INDEX_BITS : lswa_pkg::SCAN_BITS;
  localparam int RW = (RANGE_BITS > lswa_pkg::THR_BITS) ? RANGE_BITS : lswa_pkg::THR_BITS;

  logic [INDEX_BITS-1:0] sample_index;
  logic [RANGE_BITS-1:0] min_left;
  logic [RANGE_BITS-1:0] min_right;
  logic                  obstruction_seen;
  logic                  stop_seen;

  logic [CW-1:0]         idx;
  logic [RW-1:0]         rng;
  logic                  is_last;
  logic                  take;
  logic                  obs_hit;
  logic                  stop_hit;
  logic                  go_left;
  logic [RANGE_BITS-1:0] left_next;
  logic [RANGE_BITS-1:0] right_next;

  assign idx     = CW'(sample_index);
  assign rng     = RW'(range_mm);
  assign is_last = (idx >= CW'(scfg.last_idx)) || (sample_index == '1);
  assign in_ready = !q_full || !is_last;
  assign take    = in_valid && in_ready;

  assign obs_hit  = (idx > CW'(scfg.third)) && (idx < CW'(scfg.upper)) &&
                    (rng < RW'(scfg.front_thr));
  assign stop_hit = rng < RW'(scfg.stop_thr);
  assign go_left  = idx > CW'(scfg.half);

  assign left_next  = (go_left && range_mm < min_left) ? range_mm : min_left;
  assign right_next = (!go_left && range_mm < min_right) ? range_mm : min_right;

  assign q_push = take && is_last;
  assign q_data = {obstruction_seen | obs_hit, stop_seen | stop_hit, left_next, right_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index     <= '0;
      min_left         <= '1;
      min_right        <= '1;
      obstruction_seen <= 1'b0;
      stop_seen        <= 1'b0;
    end else if (take) begin
      if (is_last) begin
        sample_index     <= '0;
        min_left         <= '1;
        min_right        <= '1;
        obstruction_seen <= 1'b0;
        stop_seen        <= 1'b0;
      end else begin
        sample_index     <= sample_index + INDEX_BITS'(1);
        min_left         <= left_next;
        min_right        <= right_next;
        obstruction_seen <= obstruction_seen | obs_hit;
        stop_seen        <= stop_seen | stop_hit;
      end
    end
  end

endmodule

// ----- src/lswa_back.sv -----
// ----------------------------------------------------------------------------
// lswa_back
// turns each scan summary into a drive command, with a bit-serial episode length
// ----------------------------------------------------------------------------
module lswa_back #(
  parameter int RANGE_BITS = lswa_pkg::RANGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lswa_pkg::drive_cfg_t                 dcfg,
  input  logic                                 q_valid,
  input  logic [2*RANGE_BITS+1:0]              q_data,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lswa_pkg::SPEED_BITS-1:0]      linear_speed,
  output logic signed [lswa_pkg::TURN_BITS-1:0] turn_rate,
  output logic                                 avoiding,
  output logic                                 stopped,
  output logic [lswa_pkg::CNT_BITS-1:0]        avoid_remaining
);

  localparam int DB = lswa_pkg::DUR_BITS;
  localparam int LB = lswa_pkg::LFSR_BITS;
  localparam int NB = lswa_pkg::CNT_BITS;
  localparam int TB = lswa_pkg::TURN_BITS;
  localparam int SB = $clog2(LB + 1);

  typedef enum logic {B_IDLE, B_DIV} state_t;

  state_t          state;
  logic [NB-1:0]   avoid_counter;
  logic [TB-1:0]   held_turn_rate;
  logic [LB-1:0]   random_lfsr;
  logic [LB-1:0]   dividend;
  logic [DB:0]     rem;
  logic [DB-1:0]   dur;
  logic [SB-1:0]   steps;
  logic            ent_stop;

  logic                  e_obs;
  logic                  e_stop;
  logic [RANGE_BITS-1:0] e_min_left;
  logic [RANGE_BITS-1:0] e_min_right;
  logic                  avoid_now;
  logic                  new_episode;
  logic [DB-1:0]         dur_eff;
  logic [LB-1:0]         lfsr_adv;
  logic [TB-1:0]         turn_new;
  logic [DB:0]           rem_sh;
  logic [DB:0]           rem_nx;
  logic [lswa_pkg::SPEED_BITS-1:0] slow_speed;

  assign {e_obs, e_stop, e_min_left, e_min_right} = q_data;

  assign q_pop       = (state == B_IDLE) && q_valid && (!out_valid || out_ready);
  assign avoid_now   = e_obs || e_stop || (avoid_counter != '0);
  assign new_episode = avoid_now && (avoid_counter == '0);
  assign dur_eff     = (dcfg.dur == '0) ? DB'(1) : dcfg.dur;
  assign lfsr_adv    = lswa_pkg::lfsr_next(random_lfsr);
  assign turn_new    = (e_min_left < e_min_right) ? TB'(0) - TB'(dcfg.turn_rate)
                                                  : TB'(dcfg.turn_rate);
  assign slow_speed  = dcfg.avoid_speed;

  assign rem_sh = {rem[DB-1:0], dividend[LB-1]};
  assign rem_nx = (rem_sh >= {1'b0, dur}) ? rem_sh - {1'b0, dur} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      out_valid      <= 1'b0;
      avoid_counter  <= lswa_pkg::AVOID_CNT_RST;
      held_turn_rate <= '0;
      random_lfsr    <= lswa_pkg::LFSR_RST;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            ent_stop <= e_stop;
            if (new_episode) begin
              random_lfsr    <= lfsr_adv;
              dividend       <= lfsr_adv;
              rem            <= '0;
              dur            <= dur_eff;
              steps          <= SB'(LB);
              held_turn_rate <= turn_new;
              state          <= B_DIV;
            end else if (avoid_now) begin
              avoid_counter   <= avoid_counter - NB'(1);
              out_valid       <= 1'b1;
              linear_speed    <= e_stop ? '0 : slow_speed;
              turn_rate       <= held_turn_rate;
              avoiding        <= 1'b1;
              stopped         <= e_stop;
              avoid_remaining <= avoid_counter - NB'(1);
            end else begin
              avoid_counter   <= '0;
              held_turn_rate  <= '0;
              out_valid       <= 1'b1;
              linear_speed    <= dcfg.cruise_speed;
              turn_rate       <= '0;
              avoiding        <= 1'b0;
              stopped         <= e_stop;
              avoid_remaining <= '0;
            end
          end
        end
        B_DIV: begin
          rem      <= rem_nx;
          dividend <= {dividend[LB-2:0], 1'b0};
          steps    <= steps - SB'(1);
          if (steps == SB'(1)) begin
            avoid_counter   <= NB'(rem_nx) + NB'(dur) - NB'(1);
            out_valid       <= 1'b1;
            linear_speed    <= ent_stop ? '0 : slow_speed;
            turn_rate       <= held_turn_rate;
            avoiding        <= 1'b1;
            stopped         <= ent_stop;
            avoid_remaining <= NB'(rem_nx) + NB'(dur) - NB'(1);
            state           <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/lswa_checker.sv -----
// ----------------------------------------------------------------------------
// lswa_checker
// port-level checks on the drive command channel of the wander avoider
// ----------------------------------------------------------------------------
`include "laser_scan_wander_avoider_macros.svh"

module lswa_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [lswa_pkg::SPEED_BITS-1:0]       linear_speed,
  input logic signed [lswa_pkg::TURN_BITS-1:0] turn_rate,
  input logic                                  avoiding,
  input logic                                  stopped,
  input logic [lswa_pkg::CNT_BITS-1:0]         avoid_remaining
);

  // a stalled command holds
  `LSWA_CHECK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(linear_speed) && $stable(turn_rate) && $stable(avoiding) && $stable(avoid_remaining), "stalled command changed")

  // cruise commands go straight with no episode left and never stop
  `LSWA_CHECK(a_cruise_clean, clk, rst, out_valid && !avoiding |-> turn_rate == 16'sd0 && avoid_remaining == 9'd0 && !stopped, "cruise command not clean")

  // a stop forces an avoidance step at zero speed
  `LSWA_CHECK(a_stop_speed, clk, rst, out_valid && stopped |-> avoiding && linear_speed == 16'd0, "stop without zero speed")

  // nothing is offered right after reset
  `LSWA_CHECK_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "command offered after reset")

endmodule

bind laser_scan_wander_avoider lswa_checker u_lswa_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .linear_speed    (linear_speed),
  .turn_rate       (turn_rate),
  .avoiding        (avoiding),
  .stopped         (stopped),
  .avoid_remaining (avoid_remaining)
);
